FILE: src/assert_macros.svh
// Assertion macros shared by the sum tree sampler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge, off while reset is held.
`define STPS_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be true on a clock edge.
`define STPS_ASSERT_NEVER(lbl, cond, msg) \
    `STPS_ASSERT(lbl, !(cond), msg)

`endif

FILE: src/stps_pkg.sv
// Shared constants and types for the sum tree priority sampler.
package stps_pkg;

    // Tree geometry.
    localparam int LEAVES         = 1024;
    localparam int LEAF_W         = $clog2(LEAVES);
    localparam int NODE_AW        = LEAF_W + 1;
    localparam int PRIORITY_WIDTH = 24;
    localparam int FRACTION_WIDTH = 16;
    localparam int SUM_W          = 34;
    localparam int PROD_W         = FRACTION_WIDTH + SUM_W;

    // Stream beat widths.
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 72;
    localparam int ACT_W      = 2;

    // Action codes carried in the input tuser.
    localparam logic [ACT_W-1:0] ACT_SET    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_GET    = 2'd1;
    localparam logic [ACT_W-1:0] ACT_SAMPLE = 2'd2;

    // Sequencer states.
    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LEAF_RD,
        ST_LEAF_WT,
        ST_UP_RD,
        ST_UP_WR,
        ST_MUL,
        ST_TGT,
        ST_DN_RD,
        ST_DN_CMP,
        ST_DONE
    } st_t;

endpackage

FILE: src/stps_node_ram.sv
// Node sum memory: one write port and two registered read ports.
module stps_node_ram #(
    parameter int ADDR_W = 11,
    parameter int DATA_W = 34
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr_a,
    input  logic [ADDR_W-1:0] raddr_b,
    output logic [DATA_W-1:0] rdata_a,
    output logic [DATA_W-1:0] rdata_b
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] rdata_a_reg;
    logic [DATA_W-1:0] rdata_b_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read ports.
    always_ff @(posedge clk)
    begin
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

FILE: src/sum_tree_priority_sampler.sv
// Top level of the sum tree priority sampler: sequencer, datapath and node memory.
//
//  Channel  Dir  tdata (low bit up)                          tuser
//  s_axis   in   leaf_index, priority_req, fraction          action
//  m_axis   out  leaf_value, sampled_index, total_sum        -
//
// A set or a sample beat walks the tree from acceptance to result: the tree is
// ten levels deep and each level costs one read and one write (set) or one
// paired read and one compare (sample) on the single node memory.
// A get beat reads only its leaf, and an unused action goes straight to the result.
// After reset a clearing pass writes zero to all 2048 nodes, one per cycle,
// with s_axis_tready low. A finished result waits in the output register;
// the sequencer holds in its last state while that register is still full.
`include "assert_macros.svh"

module sum_tree_priority_sampler (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // leaf_index[9:0], priority_req[33:10], fraction[49:34], zero fill
    input  logic [stps_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    // action[1:0]
    input  logic [stps_pkg::ACT_W-1:0]        s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // leaf_value[23:0], sampled_index[33:24], total_sum[67:34], zero fill
    output logic [stps_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int LW  = stps_pkg::LEAF_W;
    localparam int AW  = stps_pkg::NODE_AW;
    localparam int PW  = stps_pkg::PRIORITY_WIDTH;
    localparam int FW  = stps_pkg::FRACTION_WIDTH;
    localparam int SW  = stps_pkg::SUM_W;
    localparam int MW  = stps_pkg::PROD_W;
    localparam logic [AW-1:0] LEAVES_N = AW'(stps_pkg::LEAVES);
    localparam logic [AW-1:0] ROOT     = AW'(1);
    localparam logic [MW-1:0] ROUND_UP = MW'((64'd1 << FW) - 64'd1);

    stps_pkg::st_t state_reg;
    stps_pkg::st_t state_next;

    logic [AW-1:0]              clr_reg;
    logic [stps_pkg::ACT_W-1:0] act_reg;
    logic [LW-1:0]              idx_reg;
    logic [PW-1:0]              prio_reg;
    logic [FW-1:0]              frac_reg;
    logic [AW-1:0]              node_reg;
    logic [SW-1:0]              delta_reg;
    logic [MW-1:0]              prod_reg;
    logic [SW-1:0]              target_reg;
    logic [SW-1:0]              total_reg;
    logic [PW-1:0]              leaf_val_reg;
    logic [LW-1:0]              samp_reg;
    logic                       out_valid_reg;
    logic [stps_pkg::OUT_DATA_W-1:0] out_data_reg;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [SW-1:0] ram_wdata;
    logic [AW-1:0] ram_raddr_a;
    logic [AW-1:0] ram_raddr_b;
    logic [SW-1:0] ram_rdata_a;
    logic [SW-1:0] ram_rdata_b;

    logic          in_beat;
    logic          out_free;
    logic          in_range;
    logic [AW-1:0] left_node;
    logic [AW-1:0] right_node;
    logic          go_right;
    logic [AW-1:0] child_node;
    logic [SW-1:0] up_sum;
    logic [MW-1:0] tgt_sum;

    assign in_beat    = s_axis_tvalid && s_axis_tready;
    assign out_free   = !out_valid_reg || m_axis_tready;
    assign in_range   = {1'b0, s_axis_tdata[LW-1:0]} < LEAVES_N;
    assign left_node  = {node_reg[AW-2:0], 1'b0};
    assign right_node = {node_reg[AW-2:0], 1'b1};
    assign go_right   = (ram_rdata_a < target_reg) && (ram_rdata_b != '0);
    assign child_node = go_right ? right_node : left_node;
    assign up_sum     = ram_rdata_a + delta_reg;
    assign tgt_sum    = prod_reg + ROUND_UP;

    stps_node_ram #(
        .ADDR_W (AW),
        .DATA_W (SW)
    ) u_node_ram (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .raddr_b (ram_raddr_b),
        .rdata_a (ram_rdata_a),
        .rdata_b (ram_rdata_b)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            stps_pkg::ST_CLEAR:
            begin
                if (clr_reg == '1)
                begin
                    state_next = stps_pkg::ST_IDLE;
                end
            end
            stps_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    case (s_axis_tuser)
                        stps_pkg::ACT_SET,
                        stps_pkg::ACT_GET:
                            state_next = in_range ? stps_pkg::ST_LEAF_RD
                                                  : stps_pkg::ST_DONE;
                        stps_pkg::ACT_SAMPLE:
                            state_next = stps_pkg::ST_MUL;
                        default:
                            state_next = stps_pkg::ST_DONE;
                    endcase
                end
            end
            stps_pkg::ST_LEAF_RD:
                state_next = stps_pkg::ST_LEAF_WT;
            stps_pkg::ST_LEAF_WT:
                state_next = (act_reg == stps_pkg::ACT_SET) ? stps_pkg::ST_UP_RD
                                                            : stps_pkg::ST_DONE;
            stps_pkg::ST_UP_RD:
                state_next = stps_pkg::ST_UP_WR;
            stps_pkg::ST_UP_WR:
                state_next = (node_reg == ROOT) ? stps_pkg::ST_DONE
                                                : stps_pkg::ST_UP_RD;
            stps_pkg::ST_MUL:
                state_next = stps_pkg::ST_TGT;
            stps_pkg::ST_TGT:
                state_next = stps_pkg::ST_DN_RD;
            stps_pkg::ST_DN_RD:
                state_next = stps_pkg::ST_DN_CMP;
            stps_pkg::ST_DN_CMP:
                state_next = child_node[LW] ? stps_pkg::ST_DONE
                                            : stps_pkg::ST_DN_RD;
            stps_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = stps_pkg::ST_IDLE;
                end
            end
            default:
                state_next = stps_pkg::ST_IDLE;
        endcase
    end

    // Memory port and handshake controls.
    always_comb
    begin
        s_axis_tready = 1'b0;
        ram_we        = 1'b0;
        ram_waddr     = node_reg;
        ram_wdata     = up_sum;
        ram_raddr_a   = node_reg;
        ram_raddr_b   = right_node;
        case (state_reg)
            stps_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
            end
            stps_pkg::ST_IDLE:
                s_axis_tready = 1'b1;
            stps_pkg::ST_LEAF_RD:
                ram_raddr_a = {1'b1, idx_reg};
            stps_pkg::ST_LEAF_WT:
            begin
                ram_we    = (act_reg == stps_pkg::ACT_SET);
                ram_wdata = SW'(prio_reg);
            end
            stps_pkg::ST_UP_WR:
                ram_we = 1'b1;
            stps_pkg::ST_DN_RD:
                ram_raddr_a = left_node;
            default:
                ram_we = 1'b0;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= stps_pkg::ST_CLEAR;
            clr_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == stps_pkg::ST_CLEAR)
            begin
                clr_reg <= clr_reg + AW'(1);
            end
            // The root write of a set also refreshes the running total.
            if (state_reg == stps_pkg::ST_UP_WR && node_reg == ROOT)
            begin
                total_reg <= up_sum;
            end
            if (state_reg == stps_pkg::ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            stps_pkg::ST_IDLE:
            begin
                act_reg      <= s_axis_tuser;
                idx_reg      <= s_axis_tdata[LW-1:0];
                prio_reg     <= s_axis_tdata[LW +: PW];
                frac_reg     <= s_axis_tdata[LW+PW +: FW];
                leaf_val_reg <= '0;
                samp_reg     <= '0;
            end
            stps_pkg::ST_LEAF_RD:
                node_reg <= {1'b1, idx_reg};
            stps_pkg::ST_LEAF_WT:
            begin
                // Leaf is written directly; ancestors take the difference.
                if (act_reg == stps_pkg::ACT_SET)
                begin
                    delta_reg <= SW'(prio_reg) - ram_rdata_a;
                    node_reg  <= node_reg >> 1;
                end
                else
                begin
                    leaf_val_reg <= ram_rdata_a[PW-1:0];
                end
            end
            stps_pkg::ST_UP_WR:
                node_reg <= node_reg >> 1;
            stps_pkg::ST_MUL:
                prod_reg <= MW'(frac_reg) * MW'(total_reg);
            stps_pkg::ST_TGT:
            begin
                // Target is the scaled total rounded up to a whole number.
                target_reg <= tgt_sum[FW +: SW];
                node_reg   <= ROOT;
            end
            stps_pkg::ST_DN_CMP:
            begin
                if (go_right)
                begin
                    target_reg <= target_reg - ram_rdata_a;
                end
                node_reg <= child_node;
                samp_reg <= child_node[LW-1:0];
            end
            stps_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg <= {4'b0, total_reg, samp_reg, leaf_val_reg};
                end
            end
            default:
                node_reg <= node_reg;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // Checks on the sequencer.
    `STPS_ASSERT_NEVER(a_idle_no_write, (state_reg == stps_pkg::ST_IDLE) && ram_we,
        "node memory written while idle")
    `STPS_ASSERT(a_one_beat, in_beat |=> !s_axis_tready,
        "second input beat taken before the first finished")
    `STPS_ASSERT(a_descent_inner,
        (state_reg == stps_pkg::ST_DN_CMP) |-> (node_reg != '0 && !node_reg[LW]),
        "descent compares below an inner node")

endmodule
